// ===== rtl/cfs_pkg.sv =====
// Package for the converter fault supervisor: item and config types,
// debounce limits, flag positions and register indexes.
// No dependencies.
package cfs_pkg;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  // Debounce and limit constants
  localparam logic [3:0] OV_DEBOUNCE    = 4'd10;
  localparam logic [6:0] UV_ON_TIME     = 7'd100;
  localparam logic [8:0] UV_STEP        = 9'd50;
  localparam logic [7:0] UV_LIMIT       = 8'd100;
  localparam logic [1:0] SHORT_LIMIT    = 2'd2;
  localparam logic [7:0] OC_DEBOUNCE    = 8'd10;
  localparam logic [7:0] OC_ZERO_MAX    = 8'd200;
  localparam logic [6:0] OT_DEBOUNCE    = 7'd100;
  localparam logic [6:0] OT_RECOVER_CNT = 7'd100;
  localparam logic [2:0] RETRY_MAX      = 3'd5;

  // Fault flag bit positions
  localparam int unsigned FLAG_OV    = 0;
  localparam int unsigned FLAG_UV    = 1;
  localparam int unsigned FLAG_OC    = 2;
  localparam int unsigned FLAG_OT    = 3;
  localparam int unsigned FLAG_SHORT = 4;

  // Register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_OV_POINT         = 3'd0,
    REG_UV_POINT         = 3'd1,
    REG_UV_MARGIN        = 3'd2,
    REG_OC_POINT         = 3'd3,
    REG_SHORT_POINT      = 3'd4,
    REG_OT_POINT         = 3'd5,
    REG_OT_RECOVER_POINT = 3'd6,
    REG_TEMP_RECOVER_EN  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0]        ov_point;
    logic [15:0]        uv_point;
    logic [11:0]        uv_margin;
    logic [15:0]        oc_point;
    logic [15:0]        short_point;
    logic signed [8:0]  ot_point;
    logic signed [8:0]  ot_recover_point;
    logic               temp_recover_enable;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    ov_point:            16'd960,
    uv_point:            16'd640,
    uv_margin:           12'd32,
    oc_point:            16'd160,
    short_point:         16'd320,
    ot_point:            9'sd100,
    ot_recover_point:    9'sd80,
    temp_recover_enable: 1'b1
  };

  typedef struct packed {
    logic               cmd;
    logic [15:0]        vout;
    logic [15:0]        iout;
    logic signed [8:0]  temperature;
    logic               converter_on;
    logic               cc_mode;
  } in_item_t;

  typedef struct packed {
    logic ov_fault;
    logic uv_fault;
    logic oc_fault;
    logic ot_fault;
    logic short_seen;
    logic force_fault;
    logic pwm_disable;
    logic zero_loop;
    logic restart;
    logic all_clear;
  } out_item_t;

endpackage

// ===== rtl/cfs_if.sv =====
// Valid/ready channel interfaces for the converter fault supervisor:
// sample/clear items in, fault status out. No dependencies.
interface cfs_in_if;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [15:0]       vout;
  logic [15:0]       iout;
  logic signed [8:0] temperature;
  logic              converter_on;
  logic              cc_mode;

  modport source (output valid, cmd, vout, iout, temperature, converter_on, cc_mode,
                  input ready);
  modport sink (input valid, cmd, vout, iout, temperature, converter_on, cc_mode,
                output ready);
endinterface

interface cfs_out_if;
  logic valid;
  logic ready;
  logic ov_fault;
  logic uv_fault;
  logic oc_fault;
  logic ot_fault;
  logic short_seen;
  logic force_fault;
  logic pwm_disable;
  logic zero_loop;
  logic restart;
  logic all_clear;

  modport source (output valid, ov_fault, uv_fault, oc_fault, ot_fault, short_seen,
                  force_fault, pwm_disable, zero_loop, restart, all_clear,
                  input ready);
  modport sink (input valid, ov_fault, uv_fault, oc_fault, ot_fault, short_seen,
                force_fault, pwm_disable, zero_loop, restart, all_clear,
                output ready);
endinterface

// ===== rtl/converter_fault_supervisor.sv =====
// Converter fault supervisor top level: input register, protection checks
// and result register. Depends on cfs_pkg, cfs_if, cfs_cfg and cfs_core.
//
// Usage:
// - in_ch carries one transaction per control tick: cmd=0 is a check tick
//   with vout, iout, temperature, converter_on and cc_mode; cmd=1 is a
//   clear request. Every input transaction yields exactly one out_ch
//   transaction with the fault flags after the item and this tick's actions
//   (force_fault, pwm_disable, zero_loop, restart).
// - Path: an accepted item is held in the input register, checked by the
//   combinational check logic and captured in the result register, which
//   drives out_ch.valid; throughput is one transaction per cycle while
//   out_ch does not stall.
// - When out_ch stalls, the result register holds; one more item may sit in
//   the input register, then in_ch.ready drops until the result is taken.
// - Thresholds sit in the cfg_ APB registers (byte address 4*index); the user
//   writes them only while the block is idle; the block does not enforce it.
// - rst_n (synchronous) empties both registers, clears all counters, flags
//   and the retry count, and restores default thresholds.
module converter_fault_supervisor
  import cfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  cfs_in_if.sink                in_ch,
  cfs_out_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t      cfg;
  in_item_t  in_r;
  logic      in_vld_r;
  out_item_t out_r;
  out_item_t res;
  logic      out_vld_r;
  logic      advance;
  logic      in_take;

  cfs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  cfs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (in_vld_r & advance),
    .cfg   (cfg),
    .item  (in_r),
    .res   (res)
  );

  assign advance     = !out_vld_r || out_ch.ready;
  assign in_ch.ready = !in_vld_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_take) in_vld_r <= 1'b1;
      else if (advance) in_vld_r <= 1'b0;
      if (advance) out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r.cmd          <= in_ch.cmd;
      in_r.vout         <= in_ch.vout;
      in_r.iout         <= in_ch.iout;
      in_r.temperature  <= in_ch.temperature;
      in_r.converter_on <= in_ch.converter_on;
      in_r.cc_mode      <= in_ch.cc_mode;
    end
    if (advance && in_vld_r) out_r <= res;
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.ov_fault    = out_r.ov_fault;
  assign out_ch.uv_fault    = out_r.uv_fault;
  assign out_ch.oc_fault    = out_r.oc_fault;
  assign out_ch.ot_fault    = out_r.ot_fault;
  assign out_ch.short_seen  = out_r.short_seen;
  assign out_ch.force_fault = out_r.force_fault;
  assign out_ch.pwm_disable = out_r.pwm_disable;
  assign out_ch.zero_loop   = out_r.zero_loop;
  assign out_ch.restart     = out_r.restart;
  assign out_ch.all_clear   = out_r.all_clear;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_vld_r && !in_vld_r)
    else $error("result or input register valid after reset");

  a_pwm_latch: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.pwm_disable |-> out_r.oc_fault && out_r.force_fault)
    else $error("pwm_disable without latched over-current");

  a_restart_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.restart |-> out_r.all_clear && !out_r.force_fault)
    else $error("restart while faults remain");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(out_r))
    else $error("stalled result changed or dropped");

endmodule

// ===== rtl/cfs_cfg.sv =====
// APB-style threshold register file for the converter fault supervisor.
// Depends on cfs_pkg.
module cfs_cfg
  import cfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_OV_POINT:         cfg_nxt.ov_point            = pwdata[15:0];
        REG_UV_POINT:         cfg_nxt.uv_point            = pwdata[15:0];
        REG_UV_MARGIN:        cfg_nxt.uv_margin           = pwdata[11:0];
        REG_OC_POINT:         cfg_nxt.oc_point            = pwdata[15:0];
        REG_SHORT_POINT:      cfg_nxt.short_point         = pwdata[15:0];
        REG_OT_POINT:         cfg_nxt.ot_point            = $signed(pwdata[8:0]);
        REG_OT_RECOVER_POINT: cfg_nxt.ot_recover_point    = $signed(pwdata[8:0]);
        REG_TEMP_RECOVER_EN:  cfg_nxt.temp_recover_enable = pwdata[0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_OV_POINT:         prdata = {16'd0, cfg_r.ov_point};
      REG_UV_POINT:         prdata = {16'd0, cfg_r.uv_point};
      REG_UV_MARGIN:        prdata = {20'd0, cfg_r.uv_margin};
      REG_OC_POINT:         prdata = {16'd0, cfg_r.oc_point};
      REG_SHORT_POINT:      prdata = {16'd0, cfg_r.short_point};
      REG_OT_POINT:         prdata = {23'd0, cfg_r.ot_point};
      REG_OT_RECOVER_POINT: prdata = {23'd0, cfg_r.ot_recover_point};
      REG_TEMP_RECOVER_EN:  prdata = {31'd0, cfg_r.temp_recover_enable};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/cfs_core.sv =====
// Protection checks for one item: debounce counters, fault flags and retry
// count, with the per-item actions. Depends on cfs_pkg.
module cfs_core
  import cfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  cfg_t      cfg,
  input  in_item_t  item,
  output out_item_t res
);

  logic [3:0] ov_cnt_r, ov_cnt_nxt;
  logic [6:0] on_cnt_r, on_cnt_nxt;
  logic [7:0] uv_cnt_r, uv_cnt_nxt;
  logic [7:0] oc_cnt_r, oc_cnt_nxt;
  logic [1:0] sc_cnt_r, sc_cnt_nxt;
  logic [6:0] ot_cnt_r, ot_cnt_nxt;
  logic [6:0] otr_cnt_r, otr_cnt_nxt;
  logic [4:0] flags_r, flags_nxt;
  logic [2:0] retry_r, retry_nxt;

  logic [16:0] uv_band;
  logic [7:0]  uv_base;
  logic [8:0]  uv_sum;
  logic        on_l;
  logic        force_l;
  logic        pwm_l;
  logic        zero_l;
  logic        restart_l;

  assign uv_band = {1'b0, cfg.uv_point} + {5'd0, cfg.uv_margin};

  always_comb begin
    ov_cnt_nxt  = ov_cnt_r;
    on_cnt_nxt  = on_cnt_r;
    uv_cnt_nxt  = uv_cnt_r;
    oc_cnt_nxt  = oc_cnt_r;
    sc_cnt_nxt  = sc_cnt_r;
    ot_cnt_nxt  = ot_cnt_r;
    otr_cnt_nxt = otr_cnt_r;
    flags_nxt   = flags_r;
    retry_nxt   = retry_r;
    uv_base     = '0;
    uv_sum      = '0;
    on_l        = item.converter_on;
    force_l     = 1'b0;
    pwm_l       = 1'b0;
    zero_l      = 1'b0;
    restart_l   = 1'b0;

    if (item.cmd) begin
      if (!flags_r[FLAG_OT]) begin
        flags_nxt[FLAG_UV] = 1'b0;
        flags_nxt[FLAG_OC] = 1'b0;
        retry_nxt = (retry_r == '1) ? retry_r : retry_r + 3'd1;
      end
      restart_l = (flags_nxt[FLAG_OT:FLAG_OV] == '0) && (retry_nxt <= RETRY_MAX);
    end else begin
      // over-voltage
      if (item.vout > cfg.ov_point)
        ov_cnt_nxt = (ov_cnt_r == '1) ? ov_cnt_r : ov_cnt_r + 4'd1;
      else
        ov_cnt_nxt = '0;
      if (ov_cnt_nxt > OV_DEBOUNCE) flags_nxt[FLAG_OV] = 1'b1;

      // under-voltage; only the current-mode band lets the count grow
      if (on_l) begin
        on_cnt_nxt = (on_cnt_r == '1) ? on_cnt_r : on_cnt_r + 7'd1;
        if (item.vout < cfg.uv_point && on_cnt_nxt > UV_ON_TIME)
          uv_base = (uv_cnt_r == '1) ? uv_cnt_r : uv_cnt_r + 8'd1;
        uv_sum = {1'b0, uv_base} + UV_STEP;
        if (item.cc_mode && ({1'b0, item.vout} < uv_band))
          uv_cnt_nxt = uv_sum[8] ? 8'hFF : uv_sum[7:0];
        else
          uv_cnt_nxt = '0;
        if (uv_cnt_nxt > UV_LIMIT) begin
          flags_nxt[FLAG_UV] = 1'b1;
          force_l = 1'b1;
          on_l    = 1'b0;
        end
      end

      // over-current, skipped while latched
      if (!flags_nxt[FLAG_OC]) begin
        if (item.iout > cfg.oc_point) begin
          if (item.iout > cfg.short_point) begin
            sc_cnt_nxt = (sc_cnt_r == '1) ? sc_cnt_r : sc_cnt_r + 2'd1;
            if (sc_cnt_nxt > SHORT_LIMIT) flags_nxt[FLAG_SHORT] = 1'b1;
          end else begin
            sc_cnt_nxt = '0;
          end
          oc_cnt_nxt = (oc_cnt_r == '1) ? oc_cnt_r : oc_cnt_r + 8'd1;
          if (oc_cnt_nxt > 8'd1 && oc_cnt_nxt < OC_ZERO_MAX) zero_l = 1'b1;
        end else begin
          oc_cnt_nxt = '0;
        end
        if (oc_cnt_nxt > OC_DEBOUNCE || sc_cnt_nxt > SHORT_LIMIT) begin
          pwm_l   = 1'b1;
          force_l = 1'b1;
          on_l    = 1'b0;
          flags_nxt[FLAG_OC] = 1'b1;
          oc_cnt_nxt = '0;
          sc_cnt_nxt = '0;
        end
      end

      // over-temperature with set and recover hysteresis
      if ($signed(item.temperature) > $signed(cfg.ot_point)) begin
        if (on_l) begin
          if (ot_cnt_r > OT_DEBOUNCE) flags_nxt[FLAG_OT] = 1'b1;
          else ot_cnt_nxt = (ot_cnt_r == '1) ? ot_cnt_r : ot_cnt_r + 7'd1;
        end
      end else begin
        ot_cnt_nxt = '0;
      end
      if (flags_nxt[FLAG_OT]) begin
        if ($signed(item.temperature) < $signed(cfg.ot_recover_point) &&
            cfg.temp_recover_enable) begin
          if (otr_cnt_r > OT_RECOVER_CNT) begin
            flags_nxt[FLAG_OT] = 1'b0;
            ot_cnt_nxt  = '0;
            otr_cnt_nxt = '0;
          end else begin
            otr_cnt_nxt = (otr_cnt_r == '1) ? otr_cnt_r : otr_cnt_r + 7'd1;
          end
        end else begin
          otr_cnt_nxt = '0;
        end
      end
    end
  end

  always_comb begin
    res.ov_fault    = flags_nxt[FLAG_OV];
    res.uv_fault    = flags_nxt[FLAG_UV];
    res.oc_fault    = flags_nxt[FLAG_OC];
    res.ot_fault    = flags_nxt[FLAG_OT];
    res.short_seen  = flags_nxt[FLAG_SHORT];
    res.force_fault = force_l;
    res.pwm_disable = pwm_l;
    res.zero_loop   = zero_l;
    res.restart     = restart_l;
    res.all_clear   = (flags_nxt[FLAG_OT:FLAG_OV] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_cnt_r  <= '0;
      on_cnt_r  <= '0;
      uv_cnt_r  <= '0;
      oc_cnt_r  <= '0;
      sc_cnt_r  <= '0;
      ot_cnt_r  <= '0;
      otr_cnt_r <= '0;
      flags_r   <= '0;
      retry_r   <= '0;
    end else if (en) begin
      ov_cnt_r  <= ov_cnt_nxt;
      on_cnt_r  <= on_cnt_nxt;
      uv_cnt_r  <= uv_cnt_nxt;
      oc_cnt_r  <= oc_cnt_nxt;
      sc_cnt_r  <= sc_cnt_nxt;
      ot_cnt_r  <= ot_cnt_nxt;
      otr_cnt_r <= otr_cnt_nxt;
      flags_r   <= flags_nxt;
      retry_r   <= retry_nxt;
    end
  end

endmodule
